FILE: sv/cc4_pkg.sv
// ---------------------------------------------------------------------------
// cc4_pkg
// Shared types, constants and helpers for the 4x4 complex Cholesky unit
// (reciprocal square root on the diagonal).
// ---------------------------------------------------------------------------
package cc4_pkg;

    localparam int WORD_BITS_DEF = 32;

    // input word: one lower-triangle Gram entry
    typedef struct packed {
        logic [1:0]         row_index;
        logic [1:0]         col_index;
        logic signed [31:0] real_part;
        logic signed [31:0] imag_part;
        logic               last_entry;
    } t_in_word;

    // output word: one factor entry
    typedef struct packed {
        logic [1:0]         out_row;
        logic [1:0]         out_col;
        logic signed [31:0] out_real;
        logic signed [31:0] out_imag;
        logic               pivot_bad;
        logic               out_last;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GRD,
        S_GCAP,
        S_LRD_B,
        S_LRD_A,
        S_LCAP,
        S_MUL,
        S_ACC,
        S_PIV,
        S_DIV,
        S_SQI,
        S_SQRT,
        S_RSL,
        S_SCL_MUL,
        S_SCL_ACC,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {A_RA_RE, A_RA_IM, A_ACC_RE, A_ACC_IM} t_a_sel;
    typedef enum logic [1:0] {B_RB_RE, B_RB_IM, B_RS} t_b_sel;
    typedef enum logic [1:0] {ACC_SUB, ACC_ADD, ACC_LOAD} t_acc_op;

    // controller to datapath
    typedef struct packed {
        logic       gram_wr;
        logic       cap_g;
        logic       cap_b;
        logic       cap_a;
        logic       mul_en;
        t_a_sel     a_sel;
        t_b_sel     b_sel;
        logic       acc_en;
        logic       acc_im;
        t_acc_op    acc_op;
        logic       set_bad;
        logic       div_init;
        logic       div_step;
        logic       div_first;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       rs_load;
        logic       out_load;
        logic       l_wr;
        logic [1:0] row;
        logic [1:0] col;
        logic [1:0] l_row;
        logic [1:0] k;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic acc_nonpos;
        logic out_free;
    } t_sts;

    // packed lower-triangle address
    function automatic logic [3:0] tri_addr(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] base;
        unique case (row)
            2'd0:    base = 4'd0;
            2'd1:    base = 4'd1;
            2'd2:    base = 4'd3;
            default: base = 4'd6;
        endcase
        return base + {2'b00, col};
    endfunction

endpackage

FILE: sv/complex_cholesky_4x4_inv_diag_unit.sv
// ---------------------------------------------------------------------------
// complex_cholesky_4x4_inv_diag_unit
// 4x4 complex Cholesky factoring with reciprocal square root pivots.
// ---------------------------------------------------------------------------
// Input channel: one lower-triangle Gram entry per word (row, column, Q7.F
// real and imaginary). Upper-triangle words are accepted and dropped. A word
// with last_entry set stores its entry and starts the factoring; o_in_stall
// stays high until the last factor word has entered the output register.
// Output channel: ten factor words in column order (0,0),(1,0),(2,0),(3,0),
// (1,1),(2,1),(3,1),(2,2),(3,2),(3,3); diagonal words carry the reciprocal
// square root of the pivot, pivot_bad flags a non-positive pivot column.
// Loading accepts one word per cycle while the unit is idle. The length of a
// factoring run is set by the shared multiplier with its operand fetches
// and by the pivot unit: a bit-serial divider and square root run for each
// positive pivot, F = WORD_BITS-8, so the default width gives Q7.24.
// Reset clears the sequencer and the output valid; stored entries are not
// cleared. A stalled output word holds, and the sequencer waits on it.
// ---------------------------------------------------------------------------
module complex_cholesky_4x4_inv_diag_unit #(
    parameter int WORD_BITS = cc4_pkg::WORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  cc4_pkg::t_in_word  i_in_word,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output cc4_pkg::t_out_word o_out_word,
    input  logic               i_out_stall
);
    import cc4_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    cc4_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // arithmetic and storage
    cc4_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule

FILE: sv/cc4_datapath.sv
// ---------------------------------------------------------------------------
// cc4_datapath
// Gram and factor stores, shared multiplier with rounding accumulator,
// bit-serial divider and square-root unit, and the output register.
// ---------------------------------------------------------------------------
module cc4_datapath #(
    parameter int WORD_BITS = cc4_pkg::WORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cc4_pkg::t_in_word i_in_word,
    input  cc4_pkg::t_cmd     i_cmd,
    output cc4_pkg::t_sts     o_sts,
    output logic              o_out_valid,
    output cc4_pkg::t_out_word o_out_word,
    input  logic              i_out_stall
);
    import cc4_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = W - 8;
    localparam int QW = 3 * F + 1;
    localparam int SW = (QW + 1) / 2;
    localparam int QE = 2 * SW;
    localparam int CW = ((SW > W) ? SW : W) + 1;

    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [2*W:0] XMAX = ((2*W+1)'(1) <<< (W-1)) - 1;
    localparam logic signed [2*W:0] XMIN = -XMAX - 1;
    localparam logic signed [2*W:0] RND  = (2*W+1)'(1) <<< (F-1);

    logic [2*W-1:0] gram_mem [0:9];
    logic [2*W-1:0] l_mem    [0:9];
    logic [2*W-1:0] r_g_rdata, r_l_rdata;

    logic signed [W-1:0] r_ra_re, r_ra_im, r_rb_re, r_rb_im;
    logic signed [W-1:0] r_acc_re, r_acc_im, r_rs;
    logic                r_bad;
    logic signed [2*W-1:0] r_prod;

    logic [W-1:0]  r_rem, r_d;
    logic [QW-1:0] r_quo;
    logic [QE-1:0] r_src;
    logic [SW+1:0] r_sq_rem;
    logic [SW-1:0] r_root;

    logic          r_out_valid;
    t_out_word     r_out;

    logic signed [W-1:0]   mul_a, mul_b, m, acc_cur, acc_new;
    logic signed [2*W:0]   rnd, shf;
    logic signed [W:0]     sum;
    logic [W-1:0]          div_t;
    logic                  div_ge;
    logic [SW+1:0]         sq_t, sq_trial;
    logic                  sq_ge;

    // gram store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.gram_wr) begin
            gram_mem[tri_addr(i_in_word.row_index, i_in_word.col_index)] <=
                {i_in_word.imag_part[W-1:0], i_in_word.real_part[W-1:0]};
        end
        r_g_rdata <= gram_mem[tri_addr(i_cmd.row, i_cmd.col)];
    end

    // factor store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.l_wr) begin
            l_mem[tri_addr(i_cmd.row, i_cmd.col)] <= {r_acc_im, r_acc_re};
        end
        r_l_rdata <= l_mem[tri_addr(i_cmd.l_row, i_cmd.k)];
    end

    // operand selection
    always_comb begin
        case (i_cmd.a_sel)
            A_RA_RE:  mul_a = r_ra_re;
            A_RA_IM:  mul_a = r_ra_im;
            A_ACC_RE: mul_a = r_acc_re;
            default:  mul_a = r_acc_im;
        endcase
        case (i_cmd.b_sel)
            B_RB_RE: mul_b = r_rb_re;
            B_RB_IM: mul_b = r_rb_im;
            default: mul_b = r_rs;
        endcase
    end

    // rounding, saturation and accumulate
    always_comb begin
        rnd = {r_prod[2*W-1], r_prod} + RND;
        shf = rnd >>> F;
        if (shf > XMAX)      m = WMAX;
        else if (shf < XMIN) m = WMIN;
        else                 m = shf[W-1:0];
        acc_cur = i_cmd.acc_im ? r_acc_im : r_acc_re;
        if (i_cmd.acc_op == ACC_ADD) sum = {acc_cur[W-1], acc_cur} + {m[W-1], m};
        else                         sum = {acc_cur[W-1], acc_cur} - {m[W-1], m};
        if (i_cmd.acc_op == ACC_LOAD)  acc_new = m;
        else if (sum[W] != sum[W-1])   acc_new = sum[W] ? WMIN : WMAX;
        else                           acc_new = sum[W-1:0];
    end

    // divider and root steps
    always_comb begin
        div_t    = {r_rem[W-2:0], i_cmd.div_first};
        div_ge   = (div_t >= r_d);
        sq_t     = {r_sq_rem[SW-1:0], r_src[QE-1 -: 2]};
        sq_trial = {r_root, 2'b01};
        sq_ge    = (sq_t >= sq_trial);
    end

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_g) begin
            r_acc_re <= r_g_rdata[W-1:0];
            r_acc_im <= r_g_rdata[2*W-1:W];
        end else if (i_cmd.acc_en) begin
            if (i_cmd.acc_im) r_acc_im <= acc_new;
            else              r_acc_re <= acc_new;
        end
        if (i_cmd.cap_b) begin
            r_rb_re <= r_l_rdata[W-1:0];
            r_rb_im <= r_l_rdata[2*W-1:W];
        end
        if (i_cmd.cap_a) begin
            r_ra_re <= r_l_rdata[W-1:0];
            r_ra_im <= r_l_rdata[2*W-1:W];
        end
        if (i_cmd.mul_en) r_prod <= mul_a * mul_b;
        if (i_cmd.set_bad) begin
            r_bad <= o_sts.acc_nonpos;
            r_rs  <= WMAX;
        end else if (i_cmd.rs_load) begin
            if (CW'(r_root) > CW'(WMAX)) r_rs <= WMAX;
            else                         r_rs <= W'(r_root);
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_quo <= '0;
            r_d   <= r_acc_re;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_t - r_d : div_t;
            r_quo <= {r_quo[QW-2:0], div_ge};
        end
        if (i_cmd.sqrt_init) begin
            r_src    <= QE'(r_quo);
            r_sq_rem <= '0;
            r_root   <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_src    <= {r_src[QE-3:0], 2'b00};
            r_sq_rem <= sq_ge ? sq_t - sq_trial : sq_t;
            r_root   <= {r_root[SW-2:0], sq_ge};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out.out_row   <= i_cmd.row;
            r_out.out_col   <= i_cmd.col;
            r_out.pivot_bad <= r_bad;
            r_out.out_last  <= (i_cmd.row == 2'd3) && (i_cmd.col == 2'd3);
            if (i_cmd.row == i_cmd.col) begin
                r_out.out_real <= 32'(r_rs);
                r_out.out_imag <= '0;
            end else begin
                r_out.out_real <= 32'(r_acc_re);
                r_out.out_imag <= 32'(r_acc_im);
            end
        end
    end

    assign o_sts.acc_nonpos = r_acc_re[W-1] || (r_acc_re == '0);
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid      = r_out_valid;
    assign o_out_word       = r_out;

endmodule

FILE: sv/cc4_ctrl.sv
// ---------------------------------------------------------------------------
// cc4_ctrl
// Sequencer: loads entries, walks columns, rows and inner products, and
// steps the divider and root unit.
// ---------------------------------------------------------------------------
module cc4_ctrl #(
    parameter int WORD_BITS = cc4_pkg::WORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  cc4_pkg::t_in_word i_in_word,
    output logic              o_in_stall,
    output cc4_pkg::t_cmd     o_cmd,
    input  cc4_pkg::t_sts     i_sts
);
    import cc4_pkg::*;

    localparam int F  = WORD_BITS - 8;
    localparam int QW = 3 * F + 1;
    localparam int SW = (QW + 1) / 2;
    localparam int CNW = $clog2(QW + 1);

    t_state r_state, n_state;
    logic [1:0] r_i, n_i, r_j, n_j, r_k, n_k, r_p, n_p;
    logic [CNW-1:0] r_cnt, n_cnt;
    logic diag, in_ok;

    assign diag  = (r_i == r_j);
    assign in_ok = i_in_word.col_index <= i_in_word.row_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
            r_p <= '0;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_i <= n_i;
            r_j <= n_j;
            r_k <= n_k;
            r_p <= n_p;
            r_cnt <= n_cnt;
        end
    end

    // next state and loop indices
    always_comb begin
        n_state = r_state;
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        n_p = r_p;
        n_cnt = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && in_ok && i_in_word.last_entry) begin
                    n_i = '0;
                    n_j = '0;
                    n_k = '0;
                    n_p = '0;
                    n_state = S_GRD;
                end
            end
            S_GRD: n_state = S_GCAP;
            S_GCAP: begin
                n_k = '0;
                n_p = '0;
                if (r_j != 2'd0) n_state = S_LRD_B;
                else             n_state = diag ? S_PIV : S_SCL_MUL;
            end
            S_LRD_B: n_state = S_LRD_A;
            S_LRD_A: n_state = S_LCAP;
            S_LCAP:  n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC: begin
                if (r_p != (diag ? 2'd1 : 2'd3)) begin
                    n_p = r_p + 2'd1;
                    n_state = S_MUL;
                end else begin
                    n_p = '0;
                    if (r_k != r_j - 2'd1) begin
                        n_k = r_k + 2'd1;
                        n_state = S_LRD_B;
                    end else begin
                        n_state = diag ? S_PIV : S_SCL_MUL;
                    end
                end
            end
            S_PIV: begin
                n_cnt = '0;
                n_state = i_sts.acc_nonpos ? S_EMIT : S_DIV;
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNW'(QW - 1)) n_state = S_SQI;
            end
            S_SQI: begin
                n_cnt = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNW'(SW - 1)) n_state = S_RSL;
            end
            S_RSL: n_state = S_EMIT;
            S_SCL_MUL: n_state = S_SCL_ACC;
            S_SCL_ACC: begin
                if (r_p == 2'd0) begin
                    n_p = 2'd1;
                    n_state = S_SCL_MUL;
                end else begin
                    n_p = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    if (r_i == 2'd3) begin
                        if (r_j == 2'd3) begin
                            n_state = S_IDLE;
                        end else begin
                            n_j = r_j + 2'd1;
                            n_i = r_j + 2'd1;
                            n_state = S_GRD;
                        end
                    end else begin
                        n_i = r_i + 2'd1;
                        n_state = S_GRD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd = '0;
        o_cmd.row   = r_i;
        o_cmd.col   = r_j;
        o_cmd.k     = r_k;
        o_cmd.l_row = r_j;
        o_cmd.a_sel = A_RA_RE;
        o_cmd.b_sel = B_RB_RE;
        o_cmd.acc_op = ACC_SUB;
        o_in_stall  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.gram_wr = i_in_valid && in_ok;
            end
            S_GCAP:  o_cmd.cap_g = 1'b1;
            S_LRD_A: begin
                o_cmd.cap_b = 1'b1;
                o_cmd.l_row = r_i;
            end
            S_LCAP: begin
                o_cmd.cap_a = 1'b1;
                o_cmd.l_row = r_i;
            end
            S_MUL, S_ACC: begin
                o_cmd.mul_en = (r_state == S_MUL);
                o_cmd.acc_en = (r_state == S_ACC);
                case (r_p)
                    2'd0: begin
                        o_cmd.a_sel = A_RA_RE;
                        o_cmd.b_sel = B_RB_RE;
                    end
                    2'd1: begin
                        o_cmd.a_sel = A_RA_IM;
                        o_cmd.b_sel = B_RB_IM;
                    end
                    2'd2: begin
                        o_cmd.a_sel = A_RA_RE;
                        o_cmd.b_sel = B_RB_IM;
                        o_cmd.acc_im = 1'b1;
                        o_cmd.acc_op = ACC_ADD;
                    end
                    default: begin
                        o_cmd.a_sel = A_RA_IM;
                        o_cmd.b_sel = B_RB_RE;
                        o_cmd.acc_im = 1'b1;
                    end
                endcase
            end
            S_PIV: begin
                o_cmd.set_bad  = 1'b1;
                o_cmd.div_init = 1'b1;
            end
            S_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_first = (r_cnt == '0);
            end
            S_SQI:  o_cmd.sqrt_init = 1'b1;
            S_SQRT: o_cmd.sqrt_step = 1'b1;
            S_RSL:  o_cmd.rs_load = 1'b1;
            S_SCL_MUL, S_SCL_ACC: begin
                o_cmd.mul_en = (r_state == S_SCL_MUL);
                o_cmd.acc_en = (r_state == S_SCL_ACC);
                o_cmd.a_sel  = (r_p == 2'd0) ? A_ACC_RE : A_ACC_IM;
                o_cmd.b_sel  = B_RS;
                o_cmd.acc_im = (r_p != 2'd0);
                o_cmd.acc_op = ACC_LOAD;
            end
            S_EMIT: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.l_wr     = i_sts.out_free && !diag;
            end
            default: ;
        endcase
    end

endmodule

FILE: bench/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the 4x4 complex Cholesky unit with reciprocal
// square root pivots: loads Gram matrices word by word, predicts the ten
// factor words of each run and compares them field by field.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cc4_pkg::*;

    localparam int FB = 24;
    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam int IDLE_LIMIT = 20000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    t_in_word  i_in_word = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;
    logic      i_out_stall = 1'b0;

    // model of the block
    longint    gram_re [10];
    longint    gram_im [10];
    t_out_word factor_q [$];

    int  n_errors = 0;
    int  idle_cycles = 0;
    bit  hold_off = 1'b0;
    bit  quiet_sink = 1'b0;

    complex_cholesky_4x4_inv_diag_unit DUT (.*);

    always #4 i_clk = ~i_clk;

    function automatic int tri_ix(int r, int c);
        return r * (r + 1) / 2 + c;
    endfunction

    function automatic longint clamp(longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    // q7.24 product, round half up then saturate
    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b + (64'sd1 <<< (FB - 1));
        return clamp(p >>> FB);
    endfunction

    // floor(sqrt(2^72 / p)) saturated to the word maximum
    function automatic longint inv_root(longint p);
        logic [127:0] num, quo, lo, hi, mid;
        num = 128'd1 << (3 * FB);
        quo = num / p;
        if (quo >= (128'd1 << 62)) return WMAX;
        lo = 0;
        hi = 128'd1 << 31;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= quo) lo = mid;
            else hi = mid - 1;
        end
        if (lo > WMAX) return WMAX;
        return longint'(lo);
    endfunction

    function automatic void push_factor(int r, int c, longint re, longint im, bit bad);
        t_out_word w;
        w.out_row = r[1:0];
        w.out_col = c[1:0];
        w.out_real = re[31:0];
        w.out_imag = im[31:0];
        w.pivot_bad = bad;
        w.out_last = (r == 3 && c == 3);
        factor_q.push_back(w);
    endfunction

    // column-by-column factoring of the stored gram entries
    function automatic void predict_factor();
        longint lr [4][4];
        longint li [4][4];
        longint piv, rs, ar, ai;
        bit bad;
        for (int j = 0; j < 4; j++) begin
            piv = gram_re[tri_ix(j, j)];
            for (int k = 0; k < j; k++) begin
                piv = clamp(piv - qmul(lr[j][k], lr[j][k]));
                piv = clamp(piv - qmul(li[j][k], li[j][k]));
            end
            bad = (piv <= 0);
            rs = bad ? WMAX : inv_root(piv);
            push_factor(j, j, rs, 0, bad);
            for (int i = j + 1; i < 4; i++) begin
                ar = gram_re[tri_ix(i, j)];
                ai = gram_im[tri_ix(i, j)];
                for (int k = 0; k < j; k++) begin
                    ar = clamp(ar - qmul(lr[i][k], lr[j][k]));
                    ar = clamp(ar - qmul(li[i][k], li[j][k]));
                    ai = clamp(ai + qmul(lr[i][k], li[j][k]));
                    ai = clamp(ai - qmul(li[i][k], lr[j][k]));
                end
                lr[i][j] = qmul(ar, rs);
                li[i][j] = qmul(ai, rs);
                push_factor(i, j, lr[i][j], li[i][j], bad);
            end
        end
    endfunction

    function automatic void model_word(t_in_word w);
        int ix;
        if (w.col_index > w.row_index) return;
        ix = tri_ix(w.row_index, w.col_index);
        gram_re[ix] = longint'(w.real_part);
        gram_im[ix] = longint'(w.imag_part);
        if (w.last_entry) predict_factor();
    endfunction

    task automatic report(string what, longint got, longint want);
        n_errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    function automatic int short_or_long_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // send one word, with a random gap before it; valid stays up between
    // back-to-back words and drops only for a gap
    task automatic send_word(t_in_word w, bit gaps = 1'b1);
        int g;
        g = gaps ? short_or_long_gap() : 0;
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_in_word  <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        model_word(w);
        @(negedge i_clk);
    endtask

    function automatic t_in_word make_word(int r, int c, longint re, longint im, bit lst);
        t_in_word w;
        w.row_index = r[1:0];
        w.col_index = c[1:0];
        w.real_part = re[31:0];
        w.imag_part = im[31:0];
        w.last_entry = lst;
        return w;
    endfunction

    function automatic longint rnd_word();
        return longint'($signed($urandom()));
    endfunction

    function automatic longint rnd_small();
        return longint'($signed($urandom_range(0, 32'h0400_0000))) - 64'sd33554432;
    endfunction

    // load a lower triangle: large diagonal (0), random (1), tiny diagonal
    task automatic send_matrix(int mode);
        longint re, im;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c <= r; c++) begin
                if (r == c) begin
                    case (mode)
                        0: re = 64'sd16777216 + $urandom_range(0, 32'h0800_0000);
                        1: re = rnd_word();
                        default: re = $urandom_range(1, 16);
                    endcase
                    im = rnd_word();
                end else begin
                    re = (mode == 1) ? rnd_word() : rnd_small();
                    im = (mode == 1) ? rnd_word() : rnd_small();
                end
                send_word(make_word(r, c, re, im, (r == 3 && c == 3)));
            end
        end
    endtask

    // extremes, identity, bad pivots, ignored and unmarked words
    task automatic test_directed();
        for (int r = 0; r < 4; r++)
            for (int c = 0; c <= r; c++)
                send_word(make_word(r, c, (r == c) ? 64'sd16777216 : 0, 0, 1'b0));
        send_word(make_word(0, 1, WMAX, WMIN, 1'b1));
        send_word(make_word(3, 3, 64'sd16777216, WMAX, 1'b1));
        send_word(make_word(0, 0, 0, 0, 1'b0));
        send_word(make_word(1, 1, WMIN, WMIN, 1'b0));
        send_word(make_word(3, 0, WMAX, WMIN, 1'b0));
        send_word(make_word(2, 1, WMIN, WMAX, 1'b0));
        send_word(make_word(3, 3, 1, -1, 1'b1));
        send_word(make_word(0, 0, WMAX, 0, 1'b0));
        send_word(make_word(2, 2, 1, 0, 1'b0));
        send_word(make_word(3, 3, -1, -1, 1'b1));
        send_word(make_word(2, 3, 0, 0, 1'b1));
    endtask

    // well-formed matrices with random content and some noise
    task automatic test_random(int n_words);
        int sent;
        t_in_word w;
        sent = 0;
        while (sent < n_words) begin
            case ($urandom_range(0, 9))
                0: begin
                    w = make_word($urandom_range(0, 3), $urandom_range(0, 3),
                                  rnd_word(), rnd_word(), $urandom_range(0, 1));
                    send_word(w);
                    sent += 1;
                end
                1: begin send_matrix(1); sent += 10; end
                2: begin send_matrix(2); sent += 10; end
                default: begin send_matrix(0); sent += 10; end
            endcase
        end
    endtask

    // receiver holds off while matrices keep coming
    task automatic test_backpressure();
        quiet_sink = 1'b1;
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(negedge i_clk);
                hold_off = 1'b0;
            end
            begin
                send_matrix(0);
                send_matrix(0);
            end
        join
        quiet_sink = 1'b0;
    endtask

    // receiver stall pattern
    initial begin
        int g;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_out_stall <= 1'b1;
            end else if (quiet_sink || $urandom_range(0, 3) != 0) begin
                i_out_stall <= 1'b0;
            end else begin
                g = short_or_long_gap() + 1;
                i_out_stall <= 1'b1;
                repeat (g) @(negedge i_clk);
                if (!hold_off) i_out_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (factor_q.size() == 0) begin
                report("unexpected word", 0, 0);
            end else begin
                want = factor_q.pop_front();
                if (o_out_word.out_row != want.out_row)
                    report("out_row", o_out_word.out_row, want.out_row);
                if (o_out_word.out_col != want.out_col)
                    report("out_col", o_out_word.out_col, want.out_col);
                if (o_out_word.out_real != want.out_real)
                    report("out_real", o_out_word.out_real, want.out_real);
                if (o_out_word.out_imag != want.out_imag)
                    report("out_imag", o_out_word.out_imag, want.out_imag);
                if (o_out_word.pivot_bad != want.pivot_bad)
                    report("pivot_bad", o_out_word.pivot_bad, want.pivot_bad);
                if (o_out_word.out_last != want.out_last)
                    report("out_last", o_out_word.out_last, want.out_last);
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 10; i++) begin
            gram_re[i] = 0;
            gram_im[i] = 0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(400);
        i_in_valid <= 1'b0;
        wait (factor_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (n_errors == 0 && factor_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/cc4_pkg.sv
sv/cc4_datapath.sv
sv/cc4_ctrl.sv
sv/complex_cholesky_4x4_inv_diag_unit.sv
bench/tb.sv
